>>> sv/pnop_pkg.sv
// Shared types and codes for the nearest opposite-parity palette search.
// Holds the request and response payload structs; no dependencies.

package pnop_pkg;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam int unsigned SIZE_WIDTH = 9;
   localparam int unsigned DIST_WIDTH = 18;

   typedef logic [7:0] channel_type;

   typedef struct packed {
      channel_type red;
      channel_type green;
      channel_type blue;
   } color_type;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  entry_index;
      channel_type red_in;
      channel_type green_in;
      channel_type blue_in;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]            nearest_index;
      channel_type           nearest_red;
      channel_type           nearest_green;
      channel_type           nearest_blue;
      logic [DIST_WIDTH-1:0] distance_squared;
      logic                  none_found;
   } rsp_payload_type;

endpackage

>>> sv/palette_nearest_opposite_parity_core.sv
// Nearest opposite-parity palette search: palette memory, scan sequencer and compare pipeline.
// Depends on pnop_pkg for the payload structs and request codes.
//
// Usage:
//   req channel (valid/ready) carries one transaction per palette write or query.
//   A write (req_type 0) stores red/green/blue at entry_index and
//   produces no response; a write at or above MAX_ENTRIES is dropped.
//   A query (req_type 1) scans every entry of opposite index parity below the
//   palette size (csr register, saturated to MAX_ENTRIES) and returns one rsp
//   transaction with the nearest index, its color and the squared distance.
//   The scan makes one memory read per cycle through the single read port, after the
//   own-color read, and ends in a two-stage square/compare drain.
//   One query in flight at a time; req_ready is high only while idle.
//   The response sits in an output register, so a new request is taken while
//   a finished response waits; a stalled receiver only holds the next query
//   at its final step until the register frees.
//   csr channel writes palette_entries (reset 256); write it only when idle.
//   Synchronous reset clears control state; palette contents are undefined
//   until written and get no clearing pass.

module palette_nearest_opposite_parity_core
   import pnop_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [SIZE_WIDTH-1:0] csr_wdata
);

   localparam int unsigned AW = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
   localparam logic [SIZE_WIDTH-1:0] CAPACITY = SIZE_WIDTH'(MAX_ENTRIES);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_OWN  = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [SIZE_WIDTH-1:0] palette_entries_ff;
   logic [SIZE_WIDTH-1:0] size_ff;
   logic [SIZE_WIDTH-1:0] scan_idx_ff;
   logic                  q_par_ff;
   logic                  q_oob_ff;
   color_type             own_ff;

   color_type             palette_mem [MAX_ENTRIES];
   color_type             rd_data_ff;
   logic                  mem_we;
   logic                  mem_re;
   logic [AW-1:0]         mem_raddr;

   // compare pipeline
   logic                  p1_ff;
   logic [7:0]            p1_idx_ff;
   logic                  p2_ff;
   logic [7:0]            p2_idx_ff;
   color_type             p2_col_ff;
   logic [15:0]           sq_r_ff, sq_g_ff, sq_b_ff;

   logic                  found_ff;
   logic [7:0]            best_idx_ff;
   color_type             best_col_ff;
   logic [DIST_WIDTH-1:0] best_dist_ff;

   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_data_ff;

   logic                  req_fire;
   logic                  scan_issue;
   logic                  rsp_free;
   logic [SIZE_WIDTH-1:0] size_sat;
   logic                  req_in_range;
   logic [7:0]            d_r, d_g, d_b;
   logic [DIST_WIDTH-1:0] cand_dist;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign size_sat = (palette_entries_ff > CAPACITY) ? CAPACITY : palette_entries_ff;
   assign req_in_range = ({1'b0, req_payload.entry_index} < CAPACITY);
   assign scan_issue = (state_ff == ST_SCAN) && (scan_idx_ff < size_ff);

   // single write port, single read port
   assign mem_we = req_fire && (req_payload.req_type == REQ_WRITE) && req_in_range;
   assign mem_re = (req_fire && (req_payload.req_type == REQ_QUERY)) || scan_issue;
   assign mem_raddr = (state_ff == ST_IDLE) ? req_payload.entry_index[AW-1:0]
                                            : scan_idx_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         palette_mem[req_payload.entry_index[AW-1:0]] <=
            '{red: req_payload.red_in, green: req_payload.green_in, blue: req_payload.blue_in};
      end
      if (mem_re) begin
         rd_data_ff <= palette_mem[mem_raddr];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_payload.req_type == REQ_QUERY)) begin
               state_in = ST_OWN;
            end
         end
         ST_OWN: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!scan_issue && !p1_ff && !p2_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         palette_entries_ff <= SIZE_WIDTH'(256);
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            palette_entries_ff <= csr_wdata;
         end
      end
   end

   // query setup and scan counter
   always_ff @(posedge clock) begin
      if (req_fire && (req_payload.req_type == REQ_QUERY)) begin
         size_ff     <= size_sat;
         q_par_ff    <= req_payload.entry_index[0];
         q_oob_ff    <= !req_in_range;
         scan_idx_ff <= {{(SIZE_WIDTH-1){1'b0}}, !req_payload.entry_index[0]};
      end else if (scan_issue) begin
         scan_idx_ff <= scan_idx_ff + SIZE_WIDTH'(2);
      end
      if (state_ff == ST_OWN) begin
         own_ff <= q_oob_ff ? '0 : rd_data_ff;
      end
   end

   // stage 1: per-channel squares of the entry just read
   assign d_r = (own_ff.red   > rd_data_ff.red)   ? own_ff.red   - rd_data_ff.red
                                                  : rd_data_ff.red   - own_ff.red;
   assign d_g = (own_ff.green > rd_data_ff.green) ? own_ff.green - rd_data_ff.green
                                                  : rd_data_ff.green - own_ff.green;
   assign d_b = (own_ff.blue  > rd_data_ff.blue)  ? own_ff.blue  - rd_data_ff.blue
                                                  : rd_data_ff.blue  - own_ff.blue;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= 1'b0;
         p2_ff <= 1'b0;
      end else begin
         p1_ff <= scan_issue;
         p2_ff <= p1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_issue) begin
         p1_idx_ff <= scan_idx_ff[7:0];
      end
      if (p1_ff) begin
         sq_r_ff   <= 16'(d_r) * 16'(d_r);
         sq_g_ff   <= 16'(d_g) * 16'(d_g);
         sq_b_ff   <= 16'(d_b) * 16'(d_b);
         p2_idx_ff <= p1_idx_ff;
         p2_col_ff <= rd_data_ff;
      end
   end

   // stage 2: sum and keep the strictly smaller distance
   assign cand_dist = DIST_WIDTH'(sq_r_ff) + DIST_WIDTH'(sq_g_ff) + DIST_WIDTH'(sq_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (req_fire && (req_payload.req_type == REQ_QUERY)) begin
         found_ff <= 1'b0;
      end else if (p2_ff) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (p2_ff && (!found_ff || (cand_dist < best_dist_ff))) begin
         best_dist_ff <= cand_dist;
         best_idx_ff  <= p2_idx_ff;
         best_col_ff  <= p2_col_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && rsp_free) begin
         if (found_ff) begin
            rsp_data_ff.nearest_index    <= best_idx_ff;
            rsp_data_ff.nearest_red      <= best_col_ff.red;
            rsp_data_ff.nearest_green    <= best_col_ff.green;
            rsp_data_ff.nearest_blue     <= best_col_ff.blue;
            rsp_data_ff.distance_squared <= best_dist_ff;
            rsp_data_ff.none_found       <= 1'b0;
         end else begin
            rsp_data_ff <= '{none_found: 1'b1, default: '0};
         end
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (p1_ff || p2_ff) |-> (state_ff == ST_SCAN))
      else $error("compare pipeline busy outside the scan");

   assert property (@(posedge clock) disable iff (reset)
      scan_issue |-> (scan_idx_ff[0] != q_par_ff))
      else $error("scan read an entry of the queried parity");

   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && found_ff) |->
         ((best_idx_ff[0] != q_par_ff) && ({1'b0, best_idx_ff} < size_ff)))
      else $error("winner has wrong parity or lies beyond the palette size");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.none_found) |->
         ((rsp_data_ff.nearest_index == 8'd0) && (rsp_data_ff.distance_squared == '0)))
      else $error("empty result carries nonzero fields");

   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && !rsp_free) |=> (state_ff == ST_DONE))
      else $error("result dropped while output register was full");
`endif

endmodule
